/* rtl/url_percent_decoder_utf8_grouping_unit_defines.svh */
// ----------------------------------------------------------------------------
// url percent decoder utf8 grouping unit - assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_UTF8_GROUPING_UNIT_DEFINES_SVH
`define URL_PERCENT_DECODER_UTF8_GROUPING_UNIT_DEFINES_SVH

// same-cycle implication
`define UPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// types, constants and helper functions of the url percent decoder
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int UPD_QUEUE_DEPTH = 2;
    localparam int UPD_ADDR_W      = 3;
    localparam int UPD_DATA_W      = 32;
    localparam int UPD_MAX_BYTES   = 3;

    localparam logic [0:0] REG_GROUP_UTF8 = 1'b0;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_HI = 8'hF6;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_esc_phase;

    typedef struct packed {
        logic [1:0]                      cnt;
        logic [UPD_MAX_BYTES-1:0][7:0]   bytes;
        logic                            last;
    } t_bundle;

    typedef struct packed {
        logic        hit;
        logic [31:0] value;
        logic [2:0]  need;
        logic [2:0]  have;
        logic [31:0] accum;
    } t_grp;

    typedef struct packed {
        logic group_utf8;
        logic wr;
    } t_cfg_ctl;

    typedef struct packed {
        logic group_open;
        logic term_load;
    } t_back_stat;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    function automatic t_grp grp_step(input logic mode, input logic [2:0] need,
                                      input logic [2:0] have, input logic [31:0] accum,
                                      input logic [7:0] b);
        t_grp       g;
        logic [3:0] h4;
        logic [2:0] h;
        logic [1:0] sh;
        g.hit   = 1'b0;
        g.value = '0;
        g.need  = need;
        g.have  = have;
        g.accum = accum;
        h4      = {1'b0, have} + 4'd1;
        h       = (h4 > {1'b0, need}) ? need : h4[2:0];
        sh      = need[1:0] - h[1:0];
        if (!mode) begin
            g.hit   = 1'b1;
            g.value = {24'b0, b};
        end else if (need == 3'd0) begin
            if (b < LEAD2_LO) begin
                g.hit   = 1'b1;
                g.value = {24'b0, b};
            end else if (b <= LEAD2_HI) begin
                g.need  = 3'd2;
                g.have  = 3'd1;
                g.accum = {16'b0, b, 8'b0};
            end else if (b <= LEAD3_HI) begin
                g.need  = 3'd3;
                g.have  = 3'd1;
                g.accum = {8'b0, b, 16'b0};
            end else if (b <= LEAD4_HI) begin
                g.need  = 3'd4;
                g.have  = 3'd1;
                g.accum = {b, 24'b0};
            end else begin
                g.hit   = 1'b1;
                g.value = '0;
            end
        end else begin
            g.have  = h;
            g.accum = accum | ({24'b0, b} << {sh, 3'b000});
            if (h == need) begin
                g.hit   = 1'b1;
                g.value = g.accum;
                g.need  = 3'd0;
                g.have  = 3'd0;
                g.accum = '0;
            end
        end
        return g;
    endfunction

endpackage

/* rtl/url_percent_decoder_utf8_grouping_unit.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder_utf8_grouping_unit
// url percent decoder with optional utf-8 code unit packing
// ----------------------------------------------------------------------------
// One character is taken per clock while the bundle queue has room. Each
// character becomes zero to three decoded bytes, plus a terminator on the
// last character of a string; the grouping stage walks these one per cycle
// while the output register can take a result. The output register hands
// out one result per cycle while the receiver pops; the first result of a
// character passes through the bundle queue and then the output register.
// A write of group_utf8 drops any partial code unit and keeps the escape
// state.
`include "url_percent_decoder_utf8_grouping_unit_defines.svh"

module url_percent_decoder_utf8_grouping_unit
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = UPD_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_in_char,
    input  logic                  i_in_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [31:0]           o_out_value,
    output logic                  o_out_end,
    output logic                  o_out_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [UPD_ADDR_W-1:0] paddr,
    input  logic [UPD_DATA_W-1:0] pwdata,
    output logic [UPD_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic       r_group_utf8;
    logic       w_cfg_wr;
    logic       w_accept;
    logic       w_f_wr;
    t_bundle    w_f_bundle;
    logic       w_q_valid;
    logic       w_q_pop;
    t_bundle    w_q_head;
    t_cfg_ctl   w_cfg;
    t_back_stat w_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[UPD_ADDR_W-1:2] == REG_GROUP_UTF8);
    assign prdata   = (paddr[UPD_ADDR_W-1:2] == REG_GROUP_UTF8) ?
                      {{(UPD_DATA_W-1){1'b0}}, r_group_utf8} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_utf8 <= 1'b0;
        end else if (w_cfg_wr) begin
            r_group_utf8 <= pwdata[0];
        end
    end

    assign w_cfg.group_utf8 = r_group_utf8;
    assign w_cfg.wr         = w_cfg_wr;
    assign w_accept         = push && !full;

    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (i_in_char),
        .i_last   (i_in_last),
        .o_wr     (w_f_wr),
        .o_bundle (w_f_bundle)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_f_wr),
        .i_data  (w_f_bundle),
        .i_rd    (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (full),
        .o_head  (w_q_head)
    );

    upd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_q_head),
        .o_q_pop   (w_q_pop),
        .i_cfg     (w_cfg),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_value   (o_out_value),
        .o_end     (o_out_end),
        .o_last    (o_out_last),
        .o_stat    (w_stat)
    );

    `UPD_ASSERT_IMPL(a_term_shape, !empty && o_out_end, (o_out_value == 32'd0) && o_out_last, "bad terminator")
    `UPD_ASSERT_NEXT(a_cfg_clears_group, w_cfg_wr, !w_stat.group_open, "group open after write")
    `UPD_ASSERT_NEXT(a_term_clears_group, w_stat.term_load, !w_stat.group_open, "group open at end")

endmodule

/* rtl/upd_front.sv */
// ----------------------------------------------------------------------------
// upd_front
// escape decoder: turns each character into a bundle of decoded bytes
// ----------------------------------------------------------------------------
module upd_front
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_wr,
    output t_bundle    o_bundle
);

    t_esc_phase r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_bundle    w_b;

    always_comb begin
        w_b       = '0;
        w_b.last  = i_last;
        n_phase   = r_phase;
        n_held    = r_held;
        case (r_phase)
            PH_IDLE: begin
                if (i_char == CH_PCT) begin
                    n_phase = PH_PCT;
                end else begin
                    w_b.bytes[w_b.cnt] = i_char;
                    w_b.cnt = w_b.cnt + 2'd1;
                end
            end
            PH_PCT: begin
                if (is_hex(i_char)) begin
                    n_held  = i_char;
                    n_phase = PH_DIGIT;
                end else begin
                    w_b.bytes[w_b.cnt] = CH_PCT;
                    w_b.cnt = w_b.cnt + 2'd1;
                    if (i_char == CH_PCT) begin
                        n_phase = PH_PCT;
                    end else begin
                        n_phase = PH_IDLE;
                        w_b.bytes[w_b.cnt] = i_char;
                        w_b.cnt = w_b.cnt + 2'd1;
                    end
                end
            end
            PH_DIGIT: begin
                if (is_hex(i_char)) begin
                    n_phase = PH_IDLE;
                    w_b.bytes[w_b.cnt] = {hex_val(r_held), hex_val(i_char)};
                    w_b.cnt = w_b.cnt + 2'd1;
                end else begin
                    w_b.bytes[w_b.cnt] = CH_PCT;
                    w_b.cnt = w_b.cnt + 2'd1;
                    w_b.bytes[w_b.cnt] = r_held;
                    w_b.cnt = w_b.cnt + 2'd1;
                    if (i_char == CH_PCT) begin
                        n_phase = PH_PCT;
                    end else begin
                        n_phase = PH_IDLE;
                        w_b.bytes[w_b.cnt] = i_char;
                        w_b.cnt = w_b.cnt + 2'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        // flush a pending escape at string end
        if (i_last) begin
            if (n_phase == PH_PCT) begin
                w_b.bytes[w_b.cnt] = CH_PCT;
                w_b.cnt = w_b.cnt + 2'd1;
            end else if (n_phase == PH_DIGIT) begin
                w_b.bytes[w_b.cnt] = CH_PCT;
                w_b.cnt = w_b.cnt + 2'd1;
                w_b.bytes[w_b.cnt] = n_held;
                w_b.cnt = w_b.cnt + 2'd1;
            end
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_wr     = i_accept;
    assign o_bundle = w_b;

endmodule

/* rtl/upd_queue.sv */
// ----------------------------------------------------------------------------
// upd_queue
// small flop queue of bundles between the escape decoder and the grouper
// ----------------------------------------------------------------------------
module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = UPD_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_data,
    input  logic    i_rd,
    output logic    o_valid,
    output logic    o_full,
    output t_bundle o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_wr && !o_full;
    assign w_pop   = i_rd && o_valid;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (w_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/upd_back.sv */
// ----------------------------------------------------------------------------
// upd_back
// walks each bundle one byte per cycle while the output can take a result, packs utf-8 groups, drives results
// ----------------------------------------------------------------------------
module upd_back
    import upd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_bundle     i_q_head,
    output logic        o_q_pop,
    input  t_cfg_ctl    i_cfg,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_value,
    output logic        o_end,
    output logic        o_last,
    output t_back_stat  o_stat
);

    logic [1:0]  r_slot, n_slot;
    logic [2:0]  r_need, n_need;
    logic [2:0]  r_have, n_have;
    logic [31:0] r_accum, n_accum;
    logic        r_ov, n_ov;
    logic [31:0] r_val, n_val;
    logic        r_end, n_end;
    logic        r_last, n_last;

    t_grp        w_g0, w_g1, w_g2;
    logic [2:0]  w_total, w_s0, w_cnt;
    logic        w_is_byte, w_is_term, w_later, w_produce, w_out_rdy, w_step, w_done;

    function automatic logic [7:0] pick(input logic [UPD_MAX_BYTES-1:0][7:0] by,
                                        input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = by[0];
            2'd1:    v = by[1];
            2'd2:    v = by[2];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    always_comb begin
        w_cnt     = {1'b0, i_q_head.cnt};
        w_total   = w_cnt + {2'b0, i_q_head.last};
        w_s0      = {1'b0, r_slot};
        w_is_byte = (w_s0 < w_cnt);
        w_is_term = !w_is_byte && i_q_head.last;
        w_g0 = grp_step(i_cfg.group_utf8, r_need, r_have, r_accum,
                        pick(i_q_head.bytes, r_slot));
        w_g1 = grp_step(i_cfg.group_utf8, w_g0.need, w_g0.have, w_g0.accum,
                        pick(i_q_head.bytes, r_slot + 2'd1));
        w_g2 = grp_step(i_cfg.group_utf8, w_g1.need, w_g1.have, w_g1.accum,
                        pick(i_q_head.bytes, r_slot + 2'd2));
        // does a later byte of this bundle give a result
        w_later   = ((w_s0 + 3'd1 < w_cnt) && w_g1.hit) ||
                    ((w_s0 + 3'd2 < w_cnt) && w_g2.hit);
        w_produce = i_q_valid && ((w_is_byte && w_g0.hit) || w_is_term);
        w_out_rdy = !r_ov || i_pop;
        w_step    = i_q_valid && (!w_produce || w_out_rdy);
        w_done    = w_step && ((w_total == 3'd0) || (w_s0 == w_total - 3'd1));
    end

    always_comb begin
        n_slot  = r_slot;
        n_need  = r_need;
        n_have  = r_have;
        n_accum = r_accum;
        n_ov    = r_ov && !i_pop;
        n_val   = r_val;
        n_end   = r_end;
        n_last  = r_last;
        if (w_step && w_total != 3'd0) begin
            if (w_is_byte) begin
                n_need  = w_g0.need;
                n_have  = w_g0.have;
                n_accum = w_g0.accum;
            end else begin
                n_need  = '0;
                n_have  = '0;
                n_accum = '0;
            end
            n_slot = w_done ? 2'd0 : r_slot + 2'd1;
        end
        if (w_produce && w_out_rdy) begin
            n_ov   = 1'b1;
            n_val  = w_is_term ? 32'd0 : w_g0.value;
            n_end  = w_is_term;
            n_last = w_is_term || (!i_q_head.last && !w_later);
        end
        // a write of the mode register drops a partial group
        if (i_cfg.wr) begin
            n_need  = '0;
            n_have  = '0;
            n_accum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_need  <= '0;
            r_have  <= '0;
            r_accum <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_need  <= n_need;
            r_have  <= n_have;
            r_accum <= n_accum;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_end  <= n_end;
        r_last <= n_last;
    end

    assign o_q_pop           = w_done;
    assign o_empty           = !r_ov;
    assign o_value           = r_val;
    assign o_end             = r_end;
    assign o_last            = r_last;
    assign o_stat.group_open = (r_need != 3'd0);
    assign o_stat.term_load  = w_produce && w_out_rdy && w_is_term;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - url percent decoder utf8 grouping unit testbench
// Characters are fed through the push/full port from a pending queue, in
// random bursts, while the result side pops on a stall pattern of its own.
// An in-bench decoder model predicts every result in byte mode and in
// grouping mode. Each popped result is checked field by field against the
// oldest prediction. Directed strings cover escapes, broken escapes, lead
// ranges and register side effects; random strings follow.
// ----------------------------------------------------------------------------
module tb_top;
    import upd_pkg::*;

    localparam logic [UPD_ADDR_W-1:0] CFG_ADDR = {REG_GROUP_UTF8, 2'b00};
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_url_char;

    typedef struct packed {
        logic [31:0] value;
        logic        term;
        logic        last;
    } t_dec_unit;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            i_in_char = 8'h00;
    logic                  i_in_last = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [31:0]           o_out_value;
    logic                  o_out_end;
    logic                  o_out_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [UPD_ADDR_W-1:0] paddr = '0;
    logic [UPD_DATA_W-1:0] pwdata = '0;
    logic [UPD_DATA_W-1:0] prdata;
    logic                  pready;

    url_percent_decoder_utf8_grouping_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .empty       (empty),
        .pop         (pop),
        .o_out_value (o_out_value),
        .o_out_end   (o_out_end),
        .o_out_last  (o_out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    t_url_char char_q[$];
    t_url_char str_buf[$];
    t_dec_unit exp_units[$];
    t_dec_unit unit_burst[$];

    // decoder model state
    logic       dec_mode = 1'b0;
    t_esc_phase dec_phase = PH_IDLE;
    logic [7:0] dec_held = 8'h00;
    logic [31:0] dec_acc = '0;
    logic [2:0] dec_need = '0;
    logic [2:0] dec_have = '0;

    int mismatches = 0;
    int chars_in = 0;
    int units_out = 0;
    int cfg_writes = 0;
    int chars_queued = 0;

    int         send_gap_max = 0;
    int         gap_left = 0;
    int         burst_left = 0;
    logic [7:0] pop_mask = 8'hFF;
    logic [2:0] pop_idx = '0;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    function automatic logic [4:0] hex_lookup(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, 4'(ch - 8'h30)};
        if (ch >= 8'h41 && ch <= 8'h46) return {1'b1, 4'(ch - 8'h41 + 8'd10)};
        if (ch >= 8'h61 && ch <= 8'h66) return {1'b1, 4'(ch - 8'h61 + 8'd10)};
        return 5'b0;
    endfunction

    function automatic void dec_clear_group();
        dec_acc = '0;
        dec_need = '0;
        dec_have = '0;
    endfunction

    function automatic void dec_unit(input logic [31:0] value, input logic term);
        t_dec_unit u;
        u.value = value;
        u.term = term;
        u.last = 1'b0;
        unit_burst.push_back(u);
    endfunction

    function automatic void dec_byte(input logic [7:0] b);
        int sh;
        if (!dec_mode) begin
            dec_unit({24'b0, b}, 1'b0);
        end else if (dec_need == 3'd0) begin
            if (b < LEAD2_LO) begin
                dec_unit({24'b0, b}, 1'b0);
            end else if (b <= LEAD2_HI) begin
                dec_need = 3'd2;
                dec_have = 3'd1;
                dec_acc = {16'b0, b, 8'b0};
            end else if (b <= LEAD3_HI) begin
                dec_need = 3'd3;
                dec_have = 3'd1;
                dec_acc = {8'b0, b, 16'b0};
            end else if (b <= LEAD4_HI) begin
                dec_need = 3'd4;
                dec_have = 3'd1;
                dec_acc = {b, 24'b0};
            end else begin
                dec_unit(32'h0, 1'b0);
            end
        end else begin
            dec_have = dec_have + 3'd1;
            if (dec_have > dec_need) dec_have = dec_need;
            sh = int'((dec_need - dec_have) & 3'd3) * 8;
            dec_acc = dec_acc | ({24'b0, b} << sh);
            if (dec_have == dec_need) begin
                dec_unit(dec_acc, 1'b0);
                dec_clear_group();
            end
        end
    endfunction

    function automatic void dec_plain(input logic [7:0] ch);
        if (ch == CH_PCT) dec_phase = PH_PCT;
        else dec_byte(ch);
    endfunction

    function automatic void dec_feed(input logic [7:0] ch, input logic last);
        logic [4:0] hx;
        logic [4:0] hh;
        unit_burst.delete();
        hx = hex_lookup(ch);
        hh = hex_lookup(dec_held);
        case (dec_phase)
            PH_PCT: begin
                if (hx[4]) begin
                    dec_held = ch;
                    dec_phase = PH_DIGIT;
                end else begin
                    dec_phase = PH_IDLE;
                    dec_byte(CH_PCT);
                    dec_plain(ch);
                end
            end
            PH_DIGIT: begin
                dec_phase = PH_IDLE;
                if (hx[4]) begin
                    dec_byte({hh[3:0], hx[3:0]});
                end else begin
                    dec_byte(CH_PCT);
                    dec_byte(dec_held);
                    dec_plain(ch);
                end
                dec_held = 8'h00;
            end
            default: dec_plain(ch);
        endcase
        if (last) begin
            if (dec_phase == PH_PCT) begin
                dec_byte(CH_PCT);
            end else if (dec_phase == PH_DIGIT) begin
                dec_byte(CH_PCT);
                dec_byte(dec_held);
            end
            dec_phase = PH_IDLE;
            dec_held = 8'h00;
            dec_clear_group();
            dec_unit(32'h0, 1'b1);
        end
        if (unit_burst.size() != 0) unit_burst[unit_burst.size() - 1].last = 1'b1;
        foreach (unit_burst[i]) exp_units.push_back(unit_burst[i]);
    endfunction

    function automatic void log_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
        if (mismatches < 10)
            $display("mismatch: %s expected %h got %h", what, want, got);
        mismatches++;
    endfunction

    // character driver
    always @(negedge i_clk) begin
        if (gap_left != 0) begin
            push <= 1'b0;
            gap_left = gap_left - 1;
        end else if (char_q.size() != 0) begin
            push <= 1'b1;
            i_in_char <= char_q[0].ch;
            i_in_last <= char_q[0].last;
            if (burst_left != 0) begin
                burst_left = burst_left - 1;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap_left = (send_gap_max == 0) ? 0 : $urandom_range(1, send_gap_max);
            end
        end else begin
            push <= 1'b0;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= pop_mask[pop_idx];
            pop_idx = pop_idx + 3'd1;
        end
    end

    // transfer monitor and checker
    always @(posedge i_clk) begin
        t_dec_unit u;
        if (i_rst_n) begin
            if (psel && penable && pready) begin
                if (pwrite && paddr == CFG_ADDR) begin
                    dec_mode = pwdata[0];
                    dec_clear_group();
                    cfg_writes++;
                end else if (!pwrite && paddr == CFG_ADDR && prdata[0] !== dec_mode) begin
                    log_mismatch("group_utf8 readback", {31'b0, dec_mode}, prdata);
                end
            end
            if (push && !full) begin
                dec_feed(i_in_char, i_in_last);
                void'(char_q.pop_front());
                chars_in++;
            end
            if (pop && !empty) begin
                units_out++;
                if (exp_units.size() == 0) begin
                    log_mismatch("unexpected result, value", 32'h0, o_out_value);
                end else begin
                    u = exp_units.pop_front();
                    if (o_out_value !== u.value) log_mismatch("out_value", u.value, o_out_value);
                    if (o_out_end !== u.term)
                        log_mismatch("out_end", {31'b0, u.term}, {31'b0, o_out_end});
                    if (o_out_last !== u.last)
                        log_mismatch("out_last", {31'b0, u.last}, {31'b0, o_out_last});
                end
            end
        end
    end

    task automatic cfg_access(input logic wr, input logic val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = CFG_ADDR;
        pwdata = {31'($urandom), val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_mode(input logic val);
        cfg_access(1'b1, val);
        cfg_access(1'b0, val);
    endtask

    task automatic wait_idle();
        while (char_q.size() != 0 || exp_units.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_char(input logic [7:0] ch);
        t_url_char c;
        c.ch = ch;
        c.last = 1'b0;
        str_buf.push_back(c);
    endfunction

    function automatic void push_string(input logic last);
        if (last && str_buf.size() != 0) str_buf[str_buf.size() - 1].last = 1'b1;
        foreach (str_buf[i]) char_q.push_back(str_buf[i]);
        chars_queued += str_buf.size();
        str_buf.delete();
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        if ($urandom_range(0, 1) != 0) return 8'h41 + 8'(n) - 8'd10;
        return 8'h61 + 8'(n) - 8'd10;
    endfunction

    function automatic void add_escape(input logic [7:0] b);
        add_char(CH_PCT);
        add_char(hex_char(b[7:4]));
        add_char(hex_char(b[3:0]));
    endfunction

    function automatic void add_coded(input logic [7:0] b);
        if ($urandom_range(0, 1) != 0) add_char(b);
        else add_escape(b);
    endfunction

    function automatic void add_utf8();
        int n;
        logic [7:0] b;
        n = $urandom_range(1, 5);
        case (n)
            1: b = 8'($urandom_range(8'h00, 8'hC1));
            2: b = 8'($urandom_range(8'hC2, 8'hDF));
            3: b = 8'($urandom_range(8'hE0, 8'hEF));
            4: b = 8'($urandom_range(8'hF0, 8'hF6));
            default: begin
                b = 8'($urandom_range(8'hF7, 8'hFF));
                n = 1;
            end
        endcase
        add_coded(b);
        for (int i = 1; i < n; i++) add_coded(8'($urandom_range(8'h80, 8'hBF)));
    endfunction

    function automatic void add_broken();
        int sub;
        logic [7:0] b;
        sub = $urandom_range(0, 3);
        add_char(CH_PCT);
        if (sub == 1 || sub == 3) add_char(hex_char(4'($urandom)));
        if (sub <= 1) begin
            do b = 8'($urandom); while (hex_lookup(b) != 5'b0);
            add_char(b);
        end
    endfunction

    function automatic void gen_string();
        int ntok;
        ntok = $urandom_range(1, 5);
        repeat (ntok) begin
            case ($urandom_range(0, 9))
                0, 1: add_char(8'($urandom));
                2, 3: add_char(8'($urandom_range(8'h20, 8'h7E)));
                4, 5: add_escape(8'($urandom));
                6, 7, 8: add_utf8();
                default: add_broken();
            endcase
        end
        push_string(1'b1);
    endfunction

    task automatic run_random(input int target, input int gap, input logic [7:0] mask,
                              input logic long_hold);
        int start;
        @(posedge i_clk);
        send_gap_max = gap;
        pop_mask = mask;
        if (long_hold) hold_req++;
        start = chars_queued;
        while (chars_queued - start < target / 2) gen_string();
        // no more strings are queued until everything so far has come out
        while (char_q.size() != 0 || exp_units.size() != 0) @(posedge i_clk);
        while (chars_queued - start < target) gen_string();
        wait_idle();
    endtask

    initial begin
        int fails;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_mode(1'b0);
        @(posedge i_clk);
        send_gap_max = 3;
        pop_mask = 8'b1011_0110;
        // escapes with digits and lower-case hex, broken escapes, zero and all-ones bytes
        add_char(8'h61);
        add_char(CH_PCT); add_char(8'h34); add_char(8'h31);
        add_char(CH_PCT); add_char(8'h36); add_char(8'h66);
        add_char(CH_PCT); add_char(8'h47);
        add_char(CH_PCT); add_char(8'h34); add_char(CH_PCT); add_char(8'h34); add_char(8'h31);
        add_char(8'h00);
        add_char(8'hFF);
        add_char(CH_PCT);
        push_string(1'b1);
        wait_idle();

        set_mode(1'b1);
        // two, three and four byte units, invalid lead, partial unit at end
        add_char(8'hC3); add_char(8'hA9);
        add_char(8'hE2); add_char(8'h82); add_char(8'hAC);
        add_char(8'hF0); add_char(8'h9F); add_char(8'h98); add_char(8'h80);
        add_char(8'hF7);
        add_char(8'hC2);
        push_string(1'b1);
        wait_idle();

        // open unit and open escape across a register write
        add_char(8'hC3);
        add_char(CH_PCT);
        push_string(1'b0);
        wait_idle();
        set_mode(1'b1);
        add_char(8'h34);
        push_string(1'b1);
        wait_idle();

        run_random(24, 4, 8'($urandom) | 8'h01, 1'b1);
        set_mode(1'b0);
        run_random(18, 0, 8'hFF, 1'b0);
        set_mode(1'b1);
        run_random(22, 8, 8'($urandom) & 8'h5B | 8'h02, 1'b0);

        fails = mismatches + exp_units.size();
        $display("run covered %0d characters and %0d results over %0d register writes,",
                 chars_in, units_out, cfg_writes);
        $display("byte and grouping modes with bursty input and stalled output");
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, exp_units.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d characters and %0d results pending",
                 char_q.size(), exp_units.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* url_percent_decoder_utf8_grouping_unit.f */
+incdir+rtl
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_utf8_grouping_unit.sv
dv/tb_top.sv
